// ===== rtl/core/scgb_pkg.sv =====
// Shared types and constants for the scan context grid builder.
// Holds request codes, register indexes and the arctangent step table.
// No dependencies.
package scgb_pkg;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CELL  = 2'd1;
  localparam logic [1:0] REQ_MEAN  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] REG_NEAR_LIMIT = 2'd0;
  localparam logic [1:0] REG_FAR_LIMIT  = 2'd1;
  localparam logic [1:0] REG_SENSOR_HT  = 2'd2;

  localparam int CORDIC_STEPS = 23;
  localparam int CORDIC_W     = 54;
  localparam int ANGLE_W      = 26;
  localparam int SUM_W        = 22;
  localparam int HEIGHT_W     = 16;
  localparam int RAD_W        = 19;

  // Arctangent of 2^-i in units of 2^-24 turn.
  function automatic logic [21:0] atan_step(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2097152;
      5'd1:    v = 22'd1238021;
      5'd2:    v = 22'd654136;
      5'd3:    v = 22'd332050;
      5'd4:    v = 22'd166669;
      5'd5:    v = 22'd83416;
      5'd6:    v = 22'd41718;
      5'd7:    v = 22'd20860;
      5'd8:    v = 22'd10430;
      5'd9:    v = 22'd5215;
      5'd10:   v = 22'd2608;
      5'd11:   v = 22'd1304;
      5'd12:   v = 22'd652;
      5'd13:   v = 22'd326;
      5'd14:   v = 22'd163;
      5'd15:   v = 22'd81;
      5'd16:   v = 22'd41;
      5'd17:   v = 22'd20;
      5'd18:   v = 22'd10;
      5'd19:   v = 22'd5;
      5'd20:   v = 22'd3;
      5'd21:   v = 22'd1;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/scgb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module scgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1200
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/scan_context_grid_builder_unit.sv =====
// Scan context grid builder: bins lidar points into a ring by sector height grid.
// An added point takes 4 multiplies, 20 root steps, a divider pass of 19+clog2(RING_COUNT+1) steps,
// 23 CORDIC steps and the sector, address and read states; a dropped point ends at the range check.
// A cell read goes through a RAM read (none when out of the grid), a ring mean through one multiply.
// One transaction at a time: the next is taken in the cycle after the result register loads.
// Reset (synchronous) and a clear zero the ring sums and sweep every cell of the cell RAM.
module scan_context_grid_builder_unit #(
  parameter int RING_COUNT   = 20,
  parameter int SECTOR_COUNT = 60
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic signed [19:0] x_mm,
  input  logic signed [19:0] y_mm,
  input  logic signed [19:0] z_mm,
  input  logic [4:0]         ring_sel,
  input  logic [5:0]         sector_sel,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               accepted,
  output logic [4:0]         ring_index,
  output logic [5:0]         sector_index,
  output logic [15:0]        value_mm
);

  localparam int CELLS  = RING_COUNT * SECTOR_COUNT;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RING_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
  localparam int SECT_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
  localparam int NUMR_W = scgb_pkg::RAD_W + $clog2(RING_COUNT + 1);
  localparam int DIV_W  = NUMR_W;
  localparam int CW     = scgb_pkg::CORDIC_W;
  localparam int ZW     = scgb_pkg::ANGLE_W;

  // The ring mean divides by a constant through a rounded-up reciprocal; exact for 22-bit sums.
  localparam int MEAN_SH = scgb_pkg::SUM_W + $clog2(SECTOR_COUNT);
  localparam logic [23:0] MEAN_RCP =
    24'(((64'd1 << MEAN_SH) + 64'(SECTOR_COUNT) - 64'd1) / 64'(SECTOR_COUNT));

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_SQRT   = 4'd3;
  localparam logic [3:0] S_RMUL   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DIVEND = 4'd6;
  localparam logic [3:0] S_CORDIC = 4'd7;
  localparam logic [3:0] S_SECT   = 4'd8;
  localparam logic [3:0] S_SECT2  = 4'd9;
  localparam logic [3:0] S_ADDR   = 4'd10;
  localparam logic [3:0] S_RD0    = 4'd11;
  localparam logic [3:0] S_RD1    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;
  localparam logic [3:0] S_CLR    = 4'd14;
  localparam logic [3:0] S_MEAN   = 4'd15;

  logic [3:0] state;
  logic [4:0] cnt;

  logic [18:0]        near_limit;
  logic [18:0]        far_limit;
  logic signed [15:0] sensor_height;

  logic [1:0]         req_q;
  logic signed [19:0] xq;
  logic signed [19:0] yq;
  logic signed [19:0] zq;

  logic [39:0] r2;
  logic [37:0] mn;
  logic [37:0] mx;
  logic [15:0] height;

  logic [39:0] sq_val;
  logic [23:0] sq_rem;
  logic [19:0] root;

  logic [DIV_W-1:0] div_num;
  logic [18:0]      div_den;
  logic [18:0]      div_rem;

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [ZW-1:0] cz;
  logic [24:0]          base_ang;
  logic [16:0]          turn;

  logic [RING_W-1:0] ring;
  logic [SECT_W-1:0] sect;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_reply;

  logic [scgb_pkg::SUM_W-1:0] ring_sum [RING_COUNT];

  logic        res_acc;
  logic [4:0]  res_ring;
  logic [5:0]  res_sect;
  logic [15:0] res_val;

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [scgb_pkg::HEIGHT_W-1:0] ram_wdata;
  logic [scgb_pkg::HEIGHT_W-1:0] ram_rdata;

  // Shared multiplier.
  logic signed [19:0] mul_a;
  logic signed [39:0] prod;

  // Root step, divider step and CORDIC step.
  logic [23:0]          sq_sh;
  logic [23:0]          sq_trial;
  logic [19:0]          div_t;
  logic signed [CW-1:0] c_dx;
  logic signed [CW-1:0] c_dy;
  logic signed [ZW-1:0] c_at;

  // Point setup terms.
  logic signed [20:0] h_sum;
  logic signed [20:0] xs;
  logic signed [20:0] ys;
  logic signed [26:0] th;
  logic [24:0]        th_c;
  logic [31:0]        sect_raw;
  logic [45:0]        mean_prod;

  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    unique case (paddr[3:2])
      scgb_pkg::REG_NEAR_LIMIT: prdata = {13'd0, near_limit};
      scgb_pkg::REG_FAR_LIMIT:  prdata = {13'd0, far_limit};
      scgb_pkg::REG_SENSOR_HT:  prdata = {16'd0, sensor_height};
      default:                  prdata = 32'd0;
    endcase
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    mul_a = xq;
      2'd1:    mul_a = yq;
      2'd2:    mul_a = {1'b0, near_limit};
      default: mul_a = {1'b0, far_limit};
    endcase
    prod = mul_a * mul_a;

    sq_sh    = {sq_rem[21:0], sq_val[39:38]};
    sq_trial = {2'b00, root, 2'b01};

    div_t = {div_rem, div_num[DIV_W-1]};

    c_dx = cy >>> cnt;
    c_dy = cx >>> cnt;
    c_at = $signed({4'd0, scgb_pkg::atan_step(cnt)});

    h_sum = {zq[19], zq} + {{5{sensor_height[15]}}, sensor_height};
    xs = xq[19] ? -{xq[19], xq} : {xq[19], xq};
    ys = xq[19] ? -{yq[19], yq} : {yq[19], yq};

    th = $signed({2'b00, base_ang}) + {cz[ZW-1], cz};
    if (th[26]) begin
      th_c = 25'd0;
    end else if (th > 27'sd16777216) begin
      th_c = 25'd16777216;
    end else begin
      th_c = th[24:0];
    end

    sect_raw = (32'(turn) * 32'(SECTOR_COUNT)) >> 16;

    mean_prod = 46'(ring_sum[ring]) * 46'(MEAN_RCP);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = height;
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_RD1 && req_q == scgb_pkg::REQ_ADD && height > ram_rdata) begin
      ram_we = 1'b1;
    end
  end

  scgb_ram #(
    .WIDTH(scgb_pkg::HEIGHT_W),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cell_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      cnt           <= '0;
      clr_addr      <= '0;
      clr_reply     <= 1'b0;
      rsp_valid     <= 1'b0;
      near_limit    <= '0;
      far_limit     <= 19'd80000;
      sensor_height <= '0;
      for (int i = 0; i < RING_COUNT; i++) begin
        ring_sum[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          scgb_pkg::REG_NEAR_LIMIT: near_limit    <= pwdata[18:0];
          scgb_pkg::REG_FAR_LIMIT:  far_limit     <= pwdata[18:0];
          scgb_pkg::REG_SENSOR_HT:  sensor_height <= pwdata[15:0];
          default: ;
        endcase
      end

      // The completion state reloads the result register itself.
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q    <= req_type;
            xq       <= x_mm;
            yq       <= y_mm;
            zq       <= z_mm;
            res_acc  <= 1'b0;
            res_ring <= '0;
            res_sect <= '0;
            res_val  <= '0;
            cnt      <= '0;
            unique case (req_type)
              scgb_pkg::REQ_ADD: begin
                state <= S_MUL;
              end
              scgb_pkg::REQ_CELL: begin
                res_ring <= ring_sel;
                res_sect <= sector_sel;
                if (32'(ring_sel) < 32'(RING_COUNT) && 32'(sector_sel) < 32'(SECTOR_COUNT)) begin
                  cell_addr <= ADDR_W'(32'(ring_sel) * 32'(SECTOR_COUNT) + 32'(sector_sel));
                  state     <= S_RD0;
                end else begin
                  state <= S_DONE;
                end
              end
              scgb_pkg::REQ_MEAN: begin
                res_ring <= ring_sel;
                if (32'(ring_sel) < 32'(RING_COUNT)) begin
                  ring  <= RING_W'(ring_sel);
                  state <= S_MEAN;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                for (int i = 0; i < RING_COUNT; i++) begin
                  ring_sum[i] <= '0;
                end
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
            endcase
          end
        end

        S_MUL: begin
          case (cnt[1:0])
            2'd0:    r2 <= 40'(prod);
            2'd1:    r2 <= r2 + 40'(prod);
            2'd2:    mn <= 38'(prod);
            default: mx <= 38'(prod);
          endcase
          cnt <= cnt + 5'd1;
          if (cnt[1:0] == 2'd3) begin
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (h_sum[20]) begin
            height <= '0;
          end else if (h_sum > 21'sd65535) begin
            height <= 16'hFFFF;
          end else begin
            height <= h_sum[15:0];
          end
          sq_val <= r2;
          sq_rem <= '0;
          root   <= '0;
          cnt    <= '0;
          if (r2 > {2'b00, mn} && r2 < {2'b00, mx}) begin
            state <= S_SQRT;
          end else begin
            state <= S_DONE;
          end
        end

        // Digit-by-digit square root, two radicand bits per step.
        S_SQRT: begin
          if (sq_sh >= sq_trial) begin
            sq_rem <= sq_sh - sq_trial;
            root   <= {root[18:0], 1'b1};
          end else begin
            sq_rem <= sq_sh;
            root   <= {root[18:0], 1'b0};
          end
          sq_val <= sq_val << 2;
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd19) begin
            state <= S_RMUL;
          end
        end

        S_RMUL: begin
          div_num <= DIV_W'(32'(root) * 32'(RING_COUNT));
          div_den <= far_limit;
          div_rem <= '0;
          cnt     <= '0;
          state   <= S_DIV;
        end

        S_MEAN: begin
          res_val <= mean_prod[MEAN_SH +: 16];
          state   <= S_DONE;
        end

        // Restoring divider, one quotient bit per step.
        S_DIV: begin
          if (div_t >= {1'b0, div_den}) begin
            div_rem <= 19'(div_t - {1'b0, div_den});
            div_num <= {div_num[DIV_W-2:0], 1'b1};
          end else begin
            div_rem <= div_t[18:0];
            div_num <= {div_num[DIV_W-2:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_W - 1)) begin
            state <= S_DIVEND;
          end
        end

        S_DIVEND: begin
          if (div_num > DIV_W'(RING_COUNT - 1)) begin
            ring <= RING_W'(RING_COUNT - 1);
          end else begin
            ring <= RING_W'(div_num);
          end
          // Points left of the y axis are turned by a half turn first.
          cx  <= {{(CW - 51){xs[20]}}, xs, 30'd0};
          cy  <= {{(CW - 51){ys[20]}}, ys, 30'd0};
          cz  <= '0;
          cnt <= '0;
          if (!xq[19]) begin
            base_ang <= 25'd8388608;
          end else if (!yq[19]) begin
            base_ang <= 25'd16777216;
          end else begin
            base_ang <= 25'd0;
          end
          state <= S_CORDIC;
        end

        S_CORDIC: begin
          if (!cy[CW-1]) begin
            cx <= cx + c_dx;
            cy <= cy - c_dy;
            cz <= cz + c_at;
          end else begin
            cx <= cx - c_dx;
            cy <= cy + c_dy;
            cz <= cz - c_at;
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(scgb_pkg::CORDIC_STEPS - 1)) begin
            state <= S_SECT;
          end
        end

        S_SECT: begin
          turn  <= 17'((26'(th_c) + 26'd128) >> 8);
          state <= S_SECT2;
        end

        S_SECT2: begin
          if (sect_raw > 32'(SECTOR_COUNT - 1)) begin
            sect <= SECT_W'(SECTOR_COUNT - 1);
          end else begin
            sect <= SECT_W'(sect_raw);
          end
          state <= S_ADDR;
        end

        S_ADDR: begin
          cell_addr <= ADDR_W'(32'(ring) * 32'(SECTOR_COUNT) + 32'(sect));
          state     <= S_RD0;
        end

        S_RD0: begin
          state <= S_RD1;
        end

        S_RD1: begin
          if (req_q == scgb_pkg::REQ_ADD) begin
            res_acc  <= 1'b1;
            res_ring <= 5'(ring);
            res_sect <= 6'(sect);
            if (height > ram_rdata) begin
              ring_sum[ring] <= ring_sum[ring] + scgb_pkg::SUM_W'(height - ram_rdata);
              res_val        <= height;
            end else begin
              res_val <= ram_rdata;
            end
          end else begin
            res_val <= ram_rdata;
          end
          state <= S_DONE;
        end

        S_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            accepted     <= res_acc;
            ring_index   <= res_ring;
            sector_index <= res_sect;
            value_mm     <= res_val;
            clr_reply    <= 1'b0;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The update step only ever addresses a cell inside the grid.
  a_update_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD1 && req_q == scgb_pkg::REQ_ADD) |->
      (32'(ring) < 32'(RING_COUNT) && 32'(sect) < 32'(SECTOR_COUNT)))
    else $error("grid update outside the grid");

  // The cell RAM is written only by the clearing sweep or a point update.
  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLR || state == S_RD1))
    else $error("unexpected cell RAM write");

  // Reset always starts the clearing sweep, so no transaction is taken.
  a_reset_sweep: assert property (@(posedge clk)
    $past(rst) |-> (req_stall && state == S_CLR))
    else $error("clearing sweep did not start after reset");

  // A result is produced only from the completion state.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("result without a completed transaction");

endmodule

// ===== tb/sv/scgb_checker.sv =====
// Scoreboard for the scan context grid builder: watches the request and response channels,
// predicts every response from its own copy of the grid and registers, and counts mismatches.
// Depends on scgb_pkg for request codes and register indexes.
`timescale 1ns / 100ps

module scgb_checker #(
  parameter int RING_COUNT   = 20,
  parameter int SECTOR_COUNT = 60
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               req_valid,
  input  logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic signed [19:0] x_mm,
  input  logic signed [19:0] y_mm,
  input  logic signed [19:0] z_mm,
  input  logic [4:0]         ring_sel,
  input  logic [5:0]         sector_sel,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic               accepted,
  input  logic [4:0]         ring_index,
  input  logic [5:0]         sector_index,
  input  logic [15:0]        value_mm,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic        acc;
    logic [4:0]  ring;
    logic [5:0]  sect;
    logic [15:0] value;
  } grid_result_t;

  logic [15:0] cell_max [RING_COUNT][SECTOR_COUNT];
  logic [21:0] ring_total [RING_COUNT];
  logic [18:0] near_limit, far_limit;
  logic [15:0] sensor_ht;
  grid_result_t expected_results [$];

  localparam longint HALF = 64'sd1 << 23;
  localparam longint FULL = 64'sd1 << 24;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 40;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // Angle of (x,y) plus a half turn, in 2^-24 turn units; arithmetic shifts floor.
  function automatic longint bearing(longint x, longint y);
    longint base, vx, vy, acc, dx, dy, th;
    longint steps [23] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                           20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
                           20, 10, 5, 3, 1, 1};
    acc = 0;
    if (x >= 0) base = HALF;
    else if (y >= 0) base = FULL;
    else base = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
    end
    vx = x <<< 30;
    vy = y <<< 30;
    for (int i = 0; i < 23; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; acc += steps[i];
      end else begin
        vx -= dx; vy += dy; acc -= steps[i];
      end
    end
    th = base + acc;
    if (th < 0) th = 0;
    if (th > FULL) th = FULL;
    return th;
  endfunction

  function automatic void clear_grid();
    foreach (cell_max[r, s]) cell_max[r][s] = '0;
    foreach (ring_total[r]) ring_total[r] = '0;
  endfunction

  function automatic grid_result_t predict_request(logic [1:0] kind, longint x, longint y,
                                                   longint z, logic [4:0] rs, logic [5:0] ss);
    grid_result_t res;
    longint unsigned r2, mn, mx, ring, t, sect;
    longint h;
    res = '0;
    case (kind)
      scgb_pkg::REQ_ADD: begin
        r2 = x * x + y * y;
        mn = longint'(near_limit) * near_limit;
        mx = longint'(far_limit) * far_limit;
        if (r2 > mn && r2 < mx) begin
          ring = (RING_COUNT * floor_sqrt(r2)) / far_limit;
          t = (bearing(x, y) + 128) >> 8;
          sect = (t * SECTOR_COUNT) >> 16;
          if (ring > RING_COUNT - 1) ring = RING_COUNT - 1;
          if (sect > SECTOR_COUNT - 1) sect = SECTOR_COUNT - 1;
          h = z + longint'($signed(sensor_ht));
          if (h < 0) h = 0;
          if (h > 65535) h = 65535;
          if (h > cell_max[ring][sect]) begin
            ring_total[ring] = ring_total[ring] + 22'(h - cell_max[ring][sect]);
            cell_max[ring][sect] = 16'(h);
          end
          res.acc = 1'b1;
          res.ring = 5'(ring);
          res.sect = 6'(sect);
          res.value = cell_max[ring][sect];
        end
      end
      scgb_pkg::REQ_CELL: begin
        res.ring = rs;
        res.sect = ss;
        if (rs < RING_COUNT && ss < SECTOR_COUNT) res.value = cell_max[rs][ss];
      end
      scgb_pkg::REQ_MEAN: begin
        res.ring = rs;
        if (rs < RING_COUNT) res.value = 16'(ring_total[rs] / SECTOR_COUNT);
      end
      default: clear_grid();
    endcase
    return res;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    grid_result_t exp_r, got;
    if (rst) begin
      clear_grid();
      near_limit <= '0;
      far_limit <= 19'd80000;
      sensor_ht <= '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          scgb_pkg::REG_NEAR_LIMIT: near_limit <= pwdata[18:0];
          scgb_pkg::REG_FAR_LIMIT:  far_limit <= pwdata[18:0];
          scgb_pkg::REG_SENSOR_HT:  sensor_ht <= pwdata[15:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        expected_results.insert(expected_results.size(),
                                predict_request(req_type, x_mm, y_mm, z_mm,
                                                ring_sel, sector_sel));
      if (rsp_valid && !rsp_stall) begin
        got = '{accepted, ring_index, sector_index, value_mm};
        if (expected_results.size() == 0) begin
          $display("%0t: response with nothing expected, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/scan_context_grid_builder_unit_tb.sv =====
// Top of the grid builder testbench: drives registers, requests and response stalls.
// Depends on scgb_pkg, scan_context_grid_builder_unit and scgb_checker.
`timescale 1ns / 100ps

module scan_context_grid_builder_unit_tb;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  logic [1:0] req_type;
  logic signed [19:0] x_mm, y_mm, z_mm;
  logic [4:0] ring_sel, ring_index;
  logic [5:0] sector_sel, sector_index;
  logic accepted;
  logic [15:0] value_mm;
  int fail_count, pending_count;
  int cycle_count;
  bit quiet_tail;

  scan_context_grid_builder_unit DUT (.*);

  scgb_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A long stall budget; reset sweeps 1200 cells and a clear costs as much.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Response stalls come in bursts until the tail of the run.
  initial begin
    int burst;
    rsp_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 6);
        rsp_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_grid();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Sends one request, with an optional random gap first. The block is busy in the cycle after
  // it takes a transaction, so dropping valid in that cycle costs nothing.
  task automatic send_request(logic [1:0] kind, logic [19:0] x, logic [19:0] y,
                              logic [19:0] z, logic [4:0] rs, logic [5:0] ss);
    if (!quiet_tail && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) @(posedge clk);
    req_valid <= 1'b1;
    req_type <= kind;
    x_mm <= x; y_mm <= y; z_mm <= z;
    ring_sel <= rs; sector_sel <= ss;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [19:0] coord(int unsigned reach);
    int v;
    v = $urandom_range(0, reach);
    if ($urandom_range(0, 1)) v = -v;
    return 20'(v);
  endfunction

  task automatic random_phase(int count);
    int unsigned pick, reach;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      reach = ($urandom_range(0, 3) == 0) ? 524287 : 90000;
      if (pick < 65)
        send_request(scgb_pkg::REQ_ADD, coord(reach), coord(reach), 20'($urandom),
                     5'($urandom), 6'($urandom));
      else if (pick < 82)
        send_request(scgb_pkg::REQ_CELL, 20'($urandom), 20'($urandom), 20'($urandom),
                     5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
      else if (pick < 98)
        send_request(scgb_pkg::REQ_MEAN, 20'($urandom), 20'($urandom), 20'($urandom),
                     5'($urandom_range(0, 31)), 6'($urandom));
      else
        send_request(scgb_pkg::REQ_CLEAR, 20'($urandom), 20'($urandom), 20'($urandom),
                     5'($urandom), 6'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cycle_count = 0;
    quiet_tail = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_valid = 1'b0; req_type = scgb_pkg::REQ_ADD;
    x_mm = '0; y_mm = '0; z_mm = '0; ring_sel = '0; sector_sel = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: origin, extremes, points in three quadrants and on both axes, reads and clear.
    send_request(scgb_pkg::REQ_ADD, 20'sd0, 20'sd0, 20'sd100, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, 20'sd1000, 20'sd0, 20'sd500, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, -20'sd1000, 20'sd0, 20'sd700, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, -20'sd1000, -20'sd1, 20'sd700, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, 20'sd0, 20'sd2000, -20'sd300, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, 20'sd0, -20'sd2000, 20'sd524287, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, 20'sd79999, 20'sd0, -20'sd524288, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, 20'sd80000, 20'sd0, 20'sd10, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, -20'sd524288, -20'sd524288, 20'sd10, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, 20'sd524287, 20'sd524287, 20'sd10, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_ADD, -20'sd56568, 20'sd56568, 20'sd9000, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_CELL, 20'sd0, 20'sd0, 20'sd0, 5'd0, 6'd29);
    send_request(scgb_pkg::REQ_CELL, 20'sd0, 20'sd0, 20'sd0, 5'd31, 6'd63);
    send_request(scgb_pkg::REQ_CELL, 20'sd0, 20'sd0, 20'sd0, 5'd19, 6'd60);
    send_request(scgb_pkg::REQ_MEAN, 20'sd0, 20'sd0, 20'sd0, 5'd0, 6'd5);
    send_request(scgb_pkg::REQ_MEAN, 20'sd0, 20'sd0, 20'sd0, 5'd20, 6'd0);
    send_request(scgb_pkg::REQ_CLEAR, 20'sd0, 20'sd0, 20'sd0, 5'd0, 6'd0);
    send_request(scgb_pkg::REQ_MEAN, 20'sd0, 20'sd0, 20'sd0, 5'd0, 6'd0);
    drain_grid();

    // Register sweep, including both ends of every range.
    write_reg(scgb_pkg::REG_NEAR_LIMIT, 32'd5000);
    write_reg(scgb_pkg::REG_FAR_LIMIT, 32'd524287);
    write_reg(scgb_pkg::REG_SENSOR_HT, 32'h0000_7FFF);
    random_phase(300);
    drain_grid();
    write_reg(scgb_pkg::REG_NEAR_LIMIT, 32'd524287);
    write_reg(scgb_pkg::REG_SENSOR_HT, 32'h0000_8000);
    random_phase(60);
    drain_grid();
    write_reg(scgb_pkg::REG_NEAR_LIMIT, 32'd0);
    write_reg(scgb_pkg::REG_FAR_LIMIT, 32'd0);
    random_phase(60);
    drain_grid();
    write_reg(scgb_pkg::REG_FAR_LIMIT, 32'd1);
    write_reg(scgb_pkg::REG_SENSOR_HT, 32'h0000_FFFF);
    random_phase(40);
    drain_grid();
    write_reg(scgb_pkg::REG_NEAR_LIMIT, 32'd200);
    write_reg(scgb_pkg::REG_FAR_LIMIT, 32'd100000);
    write_reg(scgb_pkg::REG_SENSOR_HT, 32'd1500);
    random_phase(400);
    drain_grid();
    write_reg(scgb_pkg::REG_NEAR_LIMIT, 32'd0);
    write_reg(scgb_pkg::REG_FAR_LIMIT, 32'd80000);
    write_reg(scgb_pkg::REG_SENSOR_HT, 32'd0);
    random_phase(300);
    quiet_tail = 1'b1;
    random_phase(170);

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/scgb_pkg.sv
rtl/core/scgb_ram.sv
rtl/core/scan_context_grid_builder_unit.sv
tb/sv/scgb_checker.sv
tb/sv/scan_context_grid_builder_unit_tb.sv
